@@ sv/ffra_pkg.sv @@
// shared types and constants of the first-fit region allocator
package ffra_pkg;

    localparam int MAX_BLOCKS_DEF = 32;
    localparam int ADDR_BITS_DEF  = 16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ZERO      = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_EXACT,
        S_SCAN_BIG,
        S_SCAN_FREE,
        S_SHIFT_UP,
        S_SPLIT,
        S_FREE_NEXT,
        S_FREE_PREV,
        S_SHIFT_DOWN,
        S_DONE
    } state_t;

    // sequencer controls for the table datapath
    typedef struct packed {
        logic rd_cur;   // read entry at index
        logic shift_up; // copy entry index-1 to index
        logic shift_dn; // copy entry index+1 to index
    } ctl_t;

endpackage

@@ sv/first_fit_region_allocator.sv @@
// first-fit region allocator top level with sequencer and shared compare/add unit
// Each command walks the address-ordered block table through a sequencer. The
// table sits in a memory with one write port and one registered read port, so
// each entry visited takes an address step and then a read-data step. With N
// blocks in the table, an allocate makes up to two passes, one for an exact
// fit and one for a larger block. A split then shifts the table tail up one
// entry at a time and writes both halves. A free makes one pass, checks the
// next and the previous neighbor, and shifts the tail down over the merged
// entries. A finished result waits in an output register, so the next command
// may start while that result is stalled. A config write is taken only while
// no command is in flight and no result is pending. It rebuilds the table as
// one free block.
module first_fit_region_allocator #(
    parameter int MAX_BLOCKS = ffra_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ffra_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [ADDR_BITS:0]   request_size,
    input  logic [ADDR_BITS-1:0] free_address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [ADDR_BITS-1:0] address,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ADDR_BITS:0]   cfg_data
);
    import ffra_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_BLOCKS);
    localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);
    localparam logic [ADDR_BITS:0] REGION_MAX = {1'b1, {ADDR_BITS{1'b0}}};

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic [IDX_BITS-1:0]  hit_reg, hit_next;
    logic                 phase_reg, phase_next;
    logic [1:0]           gap_reg, gap_next;
    logic                 cmd_reg;
    logic [ADDR_BITS:0]   size_reg;
    logic [ADDR_BITS-1:0] faddr_reg;
    logic [ADDR_BITS:0]   region_reg, region_next;
    logic [ADDR_BITS-1:0] hstart_reg, hstart_next;
    logic [ADDR_BITS:0]   hlen_reg, hlen_next;
    logic [2:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 ovalid_reg, ovalid_next;
    logic [2:0]           ostatus_reg;
    logic [ADDR_BITS-1:0] oaddr_reg;

    logic                 we;
    logic [IDX_BITS-1:0]  waddr, raddr;
    logic [ADDR_BITS-1:0] wstart, rstart;
    logic [ADDR_BITS:0]   wlen, rlen;
    logic                 wfree, rfree;
    logic [ADDR_BITS:0]   sum_len;
    logic                 len_eq, len_gt;
    logic                 last_idx;
    logic                 idx_past;
    logic                 in_acc, cfg_acc;
    logic                 out_load;
    logic [ADDR_BITS:0]   cfg_sat;

    ffra_table #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .ADDR_BITS (ADDR_BITS),
        .IDX_BITS  (IDX_BITS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wstart(wstart),
        .wlen  (wlen),
        .wfree (wfree),
        .raddr (raddr),
        .rstart(rstart),
        .rlen  (rlen),
        .rfree (rfree)
    );

    // handshakes
    assign in_acc    = in_valid && !in_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !ovalid_reg && !in_valid;
    assign out_valid = ovalid_reg;
    assign status    = ostatus_reg;
    assign address   = oaddr_reg;
    assign out_load  = (state_reg == S_DONE) && (!ovalid_reg || !out_stall);

    // saturated region size from the config write; a zero write becomes one
    always_comb
    begin
        if (cfg_data > REGION_MAX)
            cfg_sat = REGION_MAX;
        else if (cfg_data == '0)
            cfg_sat = (ADDR_BITS+1)'(1);
        else
            cfg_sat = cfg_data;
    end

    // shared compare and add unit
    assign len_eq   = (rlen == size_reg);
    assign len_gt   = (rlen > size_reg);
    assign sum_len  = hlen_reg + rlen;
    assign last_idx = ({1'b0, idx_reg} + (IDX_BITS+1)'(1)) >= (IDX_BITS+1)'(count_reg);
    assign idx_past = {1'b0, idx_reg} >= (IDX_BITS+1)'(count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_acc)
                    state_next = S_INIT;
                else if (in_acc)
                begin
                    if (command == CMD_FREE)
                        state_next = S_SCAN_FREE;
                    else if (request_size == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_SCAN_EXACT;
                end
            end
            S_INIT:
                state_next = S_IDLE;
            S_SCAN_EXACT:
            begin
                if (phase_reg)
                begin
                    if (rfree && len_eq)
                        state_next = S_DONE;
                    else if (last_idx)
                        state_next = S_SCAN_BIG;
                end
            end
            S_SCAN_BIG:
            begin
                if (phase_reg)
                begin
                    if (rfree && len_gt)
                        state_next = (count_reg >= CNT_BITS'(MAX_BLOCKS)) ? S_DONE
                                                                          : S_SHIFT_UP;
                    else if (last_idx)
                        state_next = S_DONE;
                end
            end
            S_SHIFT_UP:
            begin
                if (idx_reg == hit_reg)
                    state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (phase_reg)
                    state_next = S_DONE;
            end
            S_SCAN_FREE:
            begin
                if (phase_reg)
                begin
                    if (!rfree && rstart == faddr_reg && {1'b0, rlen} != 0)
                        state_next = S_FREE_NEXT;
                    else if (last_idx)
                        state_next = S_DONE;
                end
            end
            S_FREE_NEXT:
            begin
                if (phase_reg)
                    state_next = S_FREE_PREV;
            end
            S_FREE_PREV:
            begin
                if (phase_reg)
                    state_next = S_SHIFT_DOWN;
            end
            S_SHIFT_DOWN:
            begin
                if (gap_reg == 2'd0 || idx_past)
                    state_next = S_DONE;
                else if (phase_reg && last_idx)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        phase_next  = phase_reg;
        gap_next    = gap_reg;
        region_next = region_reg;
        hstart_next = hstart_reg;
        hlen_next   = hlen_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wstart      = rstart;
        wlen        = rlen;
        wfree       = rfree;
        raddr       = idx_reg;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                phase_next = 1'b0;
                gap_next   = '0;
                if (cfg_acc)
                    region_next = cfg_sat;
                else if (in_acc)
                begin
                    status_next = (command == CMD_FREE) ? ST_NOT_ALLOC
                                : (request_size == '0) ? ST_ZERO : ST_NO_FIT;
                    addr_next   = '0;
                end
            end
            S_INIT:
            begin
                we         = 1'b1;
                waddr      = '0;
                wstart     = '0;
                wlen       = region_reg;
                wfree      = 1'b1;
                count_next = CNT_BITS'(1);
            end
            S_SCAN_EXACT, S_SCAN_BIG:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (state_reg == S_SCAN_EXACT && rfree && len_eq)
                    begin
                        we          = 1'b1;
                        wfree       = 1'b0;
                        status_next = ST_OK;
                        addr_next   = rstart;
                    end
                    else if (state_reg == S_SCAN_BIG && rfree && len_gt)
                    begin
                        hit_next    = idx_reg;
                        hstart_next = rstart;
                        hlen_next   = rlen;
                        if (count_reg >= CNT_BITS'(MAX_BLOCKS))
                            status_next = ST_FULL;
                        idx_next   = IDX_BITS'(count_reg);
                        phase_next = 1'b0;
                    end
                    else if (last_idx)
                        idx_next = '0;
                    else
                        idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            S_SHIFT_UP:
            begin
                // move entry idx-1 to idx, one entry at a time
                raddr      = idx_reg - IDX_BITS'(1);
                phase_next = !phase_reg;
                if (idx_reg != hit_reg && phase_reg)
                begin
                    we       = 1'b1;
                    idx_next = idx_reg - IDX_BITS'(1);
                end
                else if (idx_reg == hit_reg)
                    phase_next = 1'b0;
            end
            S_SPLIT:
            begin
                // remainder goes to hit+1 first, then the front part is allocated
                phase_next = !phase_reg;
                we         = 1'b1;
                if (!phase_reg)
                begin
                    waddr  = hit_reg + IDX_BITS'(1);
                    wstart = hstart_reg + ADDR_BITS'(size_reg);
                    wlen   = hlen_reg - size_reg;
                    wfree  = 1'b1;
                end
                else
                begin
                    waddr       = hit_reg;
                    wstart      = hstart_reg;
                    wlen        = size_reg;
                    wfree       = 1'b0;
                    count_next  = count_reg + CNT_BITS'(1);
                    status_next = ST_OK;
                    addr_next   = hstart_reg;
                end
            end
            S_SCAN_FREE:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (!rfree && rstart == faddr_reg && {1'b0, rlen} != 0)
                    begin
                        hit_next    = idx_reg;
                        hstart_next = rstart;
                        hlen_next   = rlen;
                        status_next = ST_OK;
                        phase_next  = 1'b0;
                        idx_next    = idx_reg + IDX_BITS'(1);
                    end
                    else if (!last_idx)
                        idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            S_FREE_NEXT:
            begin
                // merge with the next block when it is free
                phase_next = !phase_reg;
                raddr      = hit_reg + IDX_BITS'(1);
                if (phase_reg)
                begin
                    idx_next = hit_reg;
                    if (({1'b0, hit_reg} + (IDX_BITS+1)'(1)) < (IDX_BITS+1)'(count_reg)
                        && rfree)
                    begin
                        hlen_next  = sum_len;
                        count_next = count_reg - CNT_BITS'(1);
                        hit_next   = hit_reg;
                        gap_next   = gap_reg + 2'd1;
                    end
                    if (hit_reg == '0)
                        idx_next = hit_reg;
                    else
                        idx_next = hit_reg - IDX_BITS'(1);
                end
            end
            S_FREE_PREV:
            begin
                // merge with the previous block when it is free
                phase_next = !phase_reg;
                raddr      = hit_reg - IDX_BITS'(1);
                if (phase_reg)
                begin
                    we    = 1'b1;
                    wfree = 1'b1;
                    if (hit_reg != '0 && rfree)
                    begin
                        waddr      = hit_reg - IDX_BITS'(1);
                        wstart     = rstart;
                        wlen       = sum_len;
                        count_next = count_reg - CNT_BITS'(1);
                        hit_next   = hit_reg - IDX_BITS'(1);
                        gap_next   = gap_reg + 2'd1;
                    end
                    else
                    begin
                        waddr  = hit_reg;
                        wstart = hstart_reg;
                        wlen   = hlen_reg;
                    end
                    idx_next = (hit_reg != '0 && rfree) ? hit_reg : hit_reg + IDX_BITS'(1);
                end
            end
            S_SHIFT_DOWN:
            begin
                // close the gap: entry idx takes entry idx + gap
                phase_next = !phase_reg;
                raddr      = idx_reg + IDX_BITS'(gap_reg);
                if (phase_reg && gap_reg != 2'd0 && !idx_past)
                begin
                    we       = 1'b1;
                    idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                    ovalid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            count_reg  <= CNT_BITS'(1);
            idx_reg    <= '0;
            hit_reg    <= '0;
            phase_reg  <= 1'b0;
            gap_reg    <= '0;
            region_reg <= REGION_MAX;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            hit_reg    <= hit_next;
            phase_reg  <= phase_next;
            gap_reg    <= gap_next;
            region_reg <= region_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg   <= command;
            size_reg  <= request_size;
            faddr_reg <= free_address;
        end
        hstart_reg <= hstart_next;
        hlen_reg   <= hlen_next;
        status_reg <= status_next;
        addr_reg   <= (cmd_reg == CMD_FREE && state_reg != S_IDLE) ? '0 : addr_next;
        // result register, loaded when the finished command hands over
        if (out_load)
        begin
            ostatus_reg <= status_reg;
            oaddr_reg   <= addr_reg;
        end
    end

`ifndef SYNTH
    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(address)))
        else $error("result changed while stalled");

    // the table never holds more entries than it has rows and is never empty
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_BITS'(MAX_BLOCKS)) && (count_reg != '0))
        else $error("block count out of range");

    // a failed command reports address zero
    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (address == '0))
        else $error("nonzero address on failure");
`endif

endmodule

@@ sv/ffra_table.sv @@
// block table memory: one write port, one registered read port
module ffra_table #(
    parameter int MAX_BLOCKS = ffra_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ffra_pkg::ADDR_BITS_DEF,
    parameter int IDX_BITS   = $clog2(MAX_BLOCKS)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_BITS-1:0]  waddr,
    input  logic [ADDR_BITS-1:0] wstart,
    input  logic [ADDR_BITS:0]   wlen,
    input  logic                 wfree,
    input  logic [IDX_BITS-1:0]  raddr,
    output logic [ADDR_BITS-1:0] rstart,
    output logic [ADDR_BITS:0]   rlen,
    output logic                 rfree
);
    import ffra_pkg::*;

    logic [ADDR_BITS-1:0] start_mem [MAX_BLOCKS];
    logic [ADDR_BITS:0]   len_mem   [MAX_BLOCKS];
    logic                 free_mem  [MAX_BLOCKS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_mem[waddr] <= wstart;
            len_mem[waddr]   <= wlen;
            free_mem[waddr]  <= wfree;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rstart <= start_mem[raddr];
        rlen   <= len_mem[raddr];
        rfree  <= free_mem[raddr];
    end

endmodule

@@ dv/tb_first_fit_region_allocator.sv @@
// testbench of the first-fit region allocator with a table-based directed part and random phases
module tb_first_fit_region_allocator;

    import ffra_pkg::*;

    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam int REGION_LIMIT = 1 << ADDR_BITS_DEF;

    typedef struct {
        logic        cmd;
        logic [16:0] size;
        logic [15:0] faddr;
        bit          typed;
        logic [2:0]  st;
        logic [15:0] addr;
    } stim_row_t;

    typedef struct {
        logic [2:0]  st;
        logic [15:0] addr;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [16:0] request_size;
    logic [15:0] free_address;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [15:0] address;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;

    // allocator shadow: address-ordered block table
    logic [16:0] tbl_start [NBLK];
    logic [16:0] tbl_len [NBLK];
    bit          tbl_free [NBLK];
    int          tbl_count;
    logic [16:0] region_bytes;

    answer_t     answer_q[$];
    int          mismatches;
    bit          noisy;

    first_fit_region_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .request_size (request_size),
        .free_address (free_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .address      (address),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // run limit
    initial
    begin
        #60000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void rebuild_table(logic [16:0] value);
        logic [16:0] v;
        v = value;
        if (v == 0)
            v = 1;
        if (v > REGION_LIMIT)
            v = REGION_LIMIT;
        region_bytes = v;
        for (int k = 0; k < NBLK; k++)
        begin
            tbl_start[k] = '0;
            tbl_len[k] = '0;
            tbl_free[k] = 1'b0;
        end
        tbl_len[0] = v;
        tbl_free[0] = 1'b1;
        tbl_count = 1;
    endfunction

    function automatic void drop_entry(int idx);
        for (int k = idx; k + 1 < tbl_count; k++)
        begin
            tbl_start[k] = tbl_start[k + 1];
            tbl_len[k] = tbl_len[k + 1];
            tbl_free[k] = tbl_free[k + 1];
        end
        tbl_count--;
        tbl_start[tbl_count] = '0;
        tbl_len[tbl_count] = '0;
        tbl_free[tbl_count] = 1'b0;
    endfunction

    // next state of the table and the answer for one command
    function automatic answer_t allocate_or_free(logic cmd, logic [16:0] size,
                                                 logic [15:0] faddr);
        answer_t r;
        int      i;
        r.st = ST_OK;
        r.addr = '0;
        if (cmd == CMD_ALLOC)
        begin
            if (size == 0)
                r.st = ST_ZERO;
            else
            begin
                for (i = 0; i < tbl_count; i++)
                    if (tbl_free[i] && tbl_len[i] == size)
                        break;
                if (i < tbl_count)
                begin
                    tbl_free[i] = 1'b0;
                    r.addr = tbl_start[i][15:0];
                end
                else
                begin
                    for (i = 0; i < tbl_count; i++)
                        if (tbl_free[i] && tbl_len[i] > size)
                            break;
                    if (i >= tbl_count)
                        r.st = ST_NO_FIT;
                    else if (tbl_count >= NBLK)
                        r.st = ST_FULL;
                    else
                    begin
                        for (int k = tbl_count; k > i + 1; k--)
                        begin
                            tbl_start[k] = tbl_start[k - 1];
                            tbl_len[k] = tbl_len[k - 1];
                            tbl_free[k] = tbl_free[k - 1];
                        end
                        tbl_start[i + 1] = tbl_start[i] + size;
                        tbl_len[i + 1] = tbl_len[i] - size;
                        tbl_free[i + 1] = 1'b1;
                        tbl_len[i] = size;
                        tbl_free[i] = 1'b0;
                        tbl_count++;
                        r.addr = tbl_start[i][15:0];
                    end
                end
            end
        end
        else
        begin
            for (i = 0; i < tbl_count; i++)
                if (!tbl_free[i] && tbl_start[i] == {1'b0, faddr})
                    break;
            if (i >= tbl_count)
                r.st = ST_NOT_ALLOC;
            else
            begin
                tbl_free[i] = 1'b1;
                // coalesce with the following and the preceding block
                if (i + 1 < tbl_count && tbl_free[i + 1])
                begin
                    tbl_len[i] = tbl_len[i] + tbl_len[i + 1];
                    drop_entry(i + 1);
                end
                if (i > 0 && tbl_free[i - 1])
                begin
                    tbl_len[i - 1] = tbl_len[i - 1] + tbl_len[i];
                    drop_entry(i);
                end
            end
        end
        return r;
    endfunction

    // one command transfer; a typed answer overrides the shadow's answer
    task automatic issue(logic cmd, logic [16:0] size, logic [15:0] faddr,
                         bit typed = 0, logic [2:0] st = ST_OK, logic [15:0] addr = '0);
        answer_t r;
        @(negedge clk);
        if (noisy && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            while ($urandom_range(0, 99) < 40)
                @(negedge clk);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        request_size <= size;
        free_address <= faddr;
        do
            @(posedge clk);
        while (in_stall);
        r = allocate_or_free(cmd, size, faddr);
        if (typed)
        begin
            r.st = st;
            r.addr = addr;
        end
        answer_q.push_back(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_region(logic [16:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        rebuild_table(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    // result checking
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d address=%0d", status, address);
            end
            else
            begin
                e = answer_q.pop_front();
                if (status !== e.st || address !== e.addr)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status=%0d address=%0d, got %0d %0d",
                                 e.st, e.addr, status, address);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_stall <= noisy && ($urandom_range(0, 99) < 16);

    initial
    begin
        stim_row_t   rows[$];
        int          regions[6];
        logic [16:0] sz;
        logic [15:0] fa;
        logic [15:0] live[$];
        logic [16:0] holes[$];
        int          pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_ALLOC;
        request_size = '0;
        free_address = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        noisy = 1'b1;
        rebuild_table(17'd65536);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, exact fit, split, coalescing on both sides
        rows = '{
            '{CMD_ALLOC, 17'd0,      16'd0,     1, ST_ZERO,      16'd0},
            '{CMD_ALLOC, 17'h1FFFF,  16'd0,     1, ST_NO_FIT,    16'd0},
            '{CMD_ALLOC, 17'd65537,  16'd0,     1, ST_NO_FIT,    16'd0},
            '{CMD_ALLOC, 17'd65536,  16'd0,     1, ST_OK,        16'd0},
            '{CMD_ALLOC, 17'd1,      16'd0,     1, ST_NO_FIT,    16'd0},
            '{CMD_FREE,  17'd0,      16'hFFFF,  1, ST_NOT_ALLOC, 16'd0},
            '{CMD_FREE,  17'd0,      16'd0,     1, ST_OK,        16'd0},
            '{CMD_FREE,  17'd0,      16'd0,     1, ST_NOT_ALLOC, 16'd0},
            '{CMD_ALLOC, 17'd100,    16'd0,     1, ST_OK,        16'd0},
            '{CMD_ALLOC, 17'd200,    16'd0,     0, ST_OK,        16'd0},
            '{CMD_ALLOC, 17'd100,    16'd0,     0, ST_OK,        16'd0},
            '{CMD_FREE,  17'd0,      16'd100,   0, ST_OK,        16'd0},
            '{CMD_ALLOC, 17'd200,    16'd0,     0, ST_OK,        16'd0},
            '{CMD_FREE,  17'd0,      16'd0,     0, ST_OK,        16'd0},
            '{CMD_FREE,  17'd0,      16'd100,   0, ST_OK,        16'd0},
            '{CMD_FREE,  17'd0,      16'd300,   0, ST_OK,        16'd0},
            '{CMD_ALLOC, 17'd65535,  16'd0,     0, ST_OK,        16'd0},
            '{CMD_ALLOC, 17'd1,      16'd0,     0, ST_OK,        16'd0},
            '{CMD_FREE,  17'd0,      16'd65535, 0, ST_OK,        16'd0},
            '{CMD_FREE,  17'd0,      16'd0,     0, ST_OK,        16'd0}
        };
        foreach (rows[n])
            issue(rows[n].cmd, rows[n].size, rows[n].faddr,
                  rows[n].typed, rows[n].st, rows[n].addr);

        // random phases over several region sizes, saturating writes among them
        regions = '{0, 64, 131071, 100, 1000, 65536};
        regions[4] = $urandom_range(2, 4096);
        for (int ph = 0; ph < 6; ph++)
        begin
            write_region(17'(regions[ph]));
            noisy = (ph != 2);
            for (int n = 0; n < 115; n++)
            begin
                if (ph == 3 && n == 57)
                    wait_drained();
                live.delete();
                holes.delete();
                for (int k = 0; k < tbl_count; k++)
                    if (tbl_free[k])
                        holes.push_back(tbl_len[k]);
                    else
                        live.push_back(tbl_start[k][15:0]);
                if ($urandom_range(0, 99) < 60)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 65)
                        sz = 17'($urandom_range(1, region_bytes / 16 + 2));
                    else if (pick < 80 && holes.size() != 0)
                        sz = holes[$urandom_range(0, holes.size() - 1)];
                    else if (pick < 92)
                        sz = 17'($urandom_range(0, 131071));
                    else
                        sz = 17'($urandom_range(0, 3));
                    fa = 16'($urandom_range(0, 65535));
                    issue(CMD_ALLOC, sz, fa);
                end
                else
                begin
                    if (live.size() != 0 && $urandom_range(0, 99) < 80)
                        fa = live[$urandom_range(0, live.size() - 1)];
                    else
                        fa = 16'($urandom_range(0, 65535));
                    sz = 17'($urandom_range(0, 131071));
                    issue(CMD_FREE, sz, fa);
                end
            end
        end

        // drain and settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
